// ===== sv/erl_pkg.sv =====
// Shared types, constants and helpers for the event ring log.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package erl_pkg;

	localparam int LOG_DEPTH_DEF = 64;

	localparam int CMD_W     = 3;
	localparam int TYPE_W    = 8;
	localparam int DETAIL_W  = 32;
	localparam int MATCH_W   = 7;
	localparam int SCORE_W   = 17;
	localparam int WEIGHT_W  = 8;
	localparam int NUM_WEIGHTS = 5;
	localparam int REG_IDX_W = 3;

	localparam logic [CMD_W-1:0] CMD_LOG   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_COUNT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SCORE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_FLUSH = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

	localparam logic [REG_IDX_W-1:0] REG_WEIGHT_HOOK       = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_WEIGHT_DEBUGGER   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_WEIGHT_REPACKAGED = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_WEIGHT_TAMPER     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_WEIGHT_SPEED      = 3'd4;

	localparam logic [TYPE_W-1:0] TYPE_TAMPER     = 8'h01;
	localparam logic [TYPE_W-1:0] TYPE_SPEED      = 8'h02;
	localparam logic [TYPE_W-1:0] TYPE_HOOK       = 8'h03;
	localparam logic [TYPE_W-1:0] TYPE_DEBUGGER   = 8'h04;
	localparam logic [TYPE_W-1:0] TYPE_REPACKAGED = 8'h05;

	typedef logic [NUM_WEIGHTS-1:0][WEIGHT_W-1:0] weights_t;

	localparam weights_t WEIGHT_RESET = {8'd3, 8'd5, 8'd15, 8'd10, 8'd10};

	typedef struct packed {
		logic [TYPE_W-1:0]   etype;
		logic [DETAIL_W-1:0] detail;
	} entry_t;

	function automatic logic [WEIGHT_W-1:0] weight_of(input logic [TYPE_W-1:0] t,
			input weights_t w);
		logic [WEIGHT_W-1:0] r;
		case (t)
			TYPE_HOOK:       r = w[REG_WEIGHT_HOOK];
			TYPE_DEBUGGER:   r = w[REG_WEIGHT_DEBUGGER];
			TYPE_REPACKAGED: r = w[REG_WEIGHT_REPACKAGED];
			TYPE_TAMPER:     r = w[REG_WEIGHT_TAMPER];
			TYPE_SPEED:      r = w[REG_WEIGHT_SPEED];
			default:         r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/erl_cell.sv =====
// One cell of the log chain: holds one entry and passes it to its neighbor.
// Depends on erl_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none
module erl_cell (
	input  wire             clk,
	input  wire             en,
	input  erl_pkg::entry_t d,
	output erl_pkg::entry_t q
);
	import erl_pkg::*;

	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (en) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule
`default_nettype wire

// ===== sv/event_ring_log_with_weighted_score_top.sv =====
// Top level of the event ring log: cell chain, walk control, weights, result register.
// Depends on erl_pkg and erl_cell.
//
//  channel | signals                                          | direction
//  req     | req_valid, req_stall, cmd, event_type, event_detail | in (stall out)
//  rsp     | rsp_valid, rsp_stall, out_type, out_detail,      | out (stall in)
//          | match_count, weighted_score, last_item           |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data         | in (ready out)
//
// Log, clear and unknown commands leave req_stall low. Count, score and flush rotate the
// cell chain once around: LOG_DEPTH steps, one per cycle while the result register is
// free, so req_stall stays high from the accept until the last step, and any result that
// rsp_stall holds delays the steps.
// Newest entry sits in cell 0; the tail cell sees entries oldest first.
// Reset empties the log and loads the default weights; entries need no reset.
`timescale 1ns / 1ps
`default_nettype none
module event_ring_log_with_weighted_score_top #(
	parameter int LOG_DEPTH = erl_pkg::LOG_DEPTH_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 req_valid,
	output logic                                req_stall,
	input  wire  [erl_pkg::CMD_W-1:0]           cmd,
	input  wire  [erl_pkg::TYPE_W-1:0]          event_type,
	input  wire  [erl_pkg::DETAIL_W-1:0]        event_detail,
	output logic                                rsp_valid,
	input  wire                                 rsp_stall,
	output logic [erl_pkg::TYPE_W-1:0]          out_type,
	output logic [erl_pkg::DETAIL_W-1:0]        out_detail,
	output logic [erl_pkg::MATCH_W-1:0]         match_count,
	output logic [erl_pkg::SCORE_W-1:0]         weighted_score,
	output logic                                last_item,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [erl_pkg::REG_IDX_W-1:0]       cfg_index,
	input  wire  [erl_pkg::WEIGHT_W-1:0]        cfg_data
);
	import erl_pkg::*;

	localparam int K_W   = $clog2(LOG_DEPTH);
	localparam int CNT_W = $clog2(LOG_DEPTH + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WALK = 1'b1;

	logic                 state_q;
	logic [K_W-1:0]       step_q;
	logic [CNT_W-1:0]     fill_q;
	logic [CMD_W-1:0]     cmd_q;
	logic [TYPE_W-1:0]    qtype_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [SCORE_W-1:0]   score_q;
	weights_t             weights_q;

	logic                 rsp_valid_q;
	logic [TYPE_W-1:0]    out_type_q;
	logic [DETAIL_W-1:0]  out_detail_q;
	logic [MATCH_W-1:0]   match_q;
	logic [SCORE_W-1:0]   wscore_q;
	logic                 last_q;

	entry_t chain [LOG_DEPTH];
	entry_t head_d;
	entry_t tail;
	logic   accept;
	logic   log_en;
	logic   out_free;
	logic   advance;
	logic   final_step;
	logic   tail_held;
	logic [CNT_W:0]       pos_sum;
	logic [CNT_W-1:0]     cnt_next;
	logic [SCORE_W-1:0]   score_next;
	logic                 load_out;

	assign accept     = req_valid && !req_stall;
	assign req_stall  = (state_q != ST_IDLE);
	assign cfg_ready  = 1'b1;
	assign log_en     = accept && (cmd == CMD_LOG);
	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign advance    = (state_q == ST_WALK) && out_free;
	assign final_step = (step_q == K_W'(LOG_DEPTH - 1));
	assign tail       = chain[LOG_DEPTH-1];
	assign pos_sum    = (CNT_W+1)'(step_q) + (CNT_W+1)'(fill_q);
	assign tail_held  = (pos_sum >= (CNT_W+1)'(LOG_DEPTH));

	assign head_d = log_en ? entry_t'{etype: event_type, detail: event_detail} : tail;

	genvar gi;
	generate
		for (gi = 0; gi < LOG_DEPTH; gi++) begin : g_cell
			erl_cell u_cell (
				.clk (clk),
				.en  (log_en || advance),
				.d   ((gi == 0) ? head_d : chain[(gi == 0) ? 0 : gi - 1]),
				.q   (chain[gi])
			);
		end
	endgenerate

	always_comb begin
		cnt_next   = cnt_q;
		score_next = score_q;
		if (tail_held && (tail.etype == qtype_q)) begin
			cnt_next = cnt_q + CNT_W'(1);
		end
		if (tail_held) begin
			score_next = score_q + SCORE_W'(weight_of(tail.etype, weights_q));
		end
	end

	always_comb begin
		load_out = 1'b0;
		if (advance) begin
			case (cmd_q)
				CMD_FLUSH:             load_out = tail_held;
				CMD_COUNT, CMD_SCORE:  load_out = final_step;
				default:               load_out = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
			fill_q    <= '0;
			cmd_q     <= CMD_LOG;
			weights_q <= WEIGHT_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WEIGHT_HOOK:       weights_q[REG_WEIGHT_HOOK]       <= cfg_data;
					REG_WEIGHT_DEBUGGER:   weights_q[REG_WEIGHT_DEBUGGER]   <= cfg_data;
					REG_WEIGHT_REPACKAGED: weights_q[REG_WEIGHT_REPACKAGED] <= cfg_data;
					REG_WEIGHT_TAMPER:     weights_q[REG_WEIGHT_TAMPER]     <= cfg_data;
					REG_WEIGHT_SPEED:      weights_q[REG_WEIGHT_SPEED]      <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				cmd_q <= cmd;
				case (cmd)
					CMD_LOG: begin
						if (fill_q != CNT_W'(LOG_DEPTH)) begin
							fill_q <= fill_q + CNT_W'(1);
						end
					end
					CMD_CLEAR: fill_q <= '0;
					CMD_COUNT, CMD_SCORE, CMD_FLUSH: begin
						state_q <= ST_WALK;
						step_q  <= '0;
					end
					default: ;
				endcase
			end
			if (advance) begin
				if (final_step) begin
					state_q <= ST_IDLE;
					step_q  <= '0;
				end else begin
					step_q <= step_q + K_W'(1);
				end
			end
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			qtype_q <= event_type;
			cnt_q   <= '0;
			score_q <= '0;
		end else if (advance) begin
			cnt_q   <= cnt_next;
			score_q <= score_next;
		end
		if (load_out) begin
			case (cmd_q)
				CMD_FLUSH: begin
					out_type_q   <= tail.etype;
					out_detail_q <= tail.detail;
					match_q      <= '0;
					wscore_q     <= '0;
					last_q       <= final_step;
				end
				CMD_COUNT: begin
					out_type_q   <= '0;
					out_detail_q <= '0;
					match_q      <= MATCH_W'(cnt_next);
					wscore_q     <= '0;
					last_q       <= 1'b1;
				end
				CMD_SCORE: begin
					out_type_q   <= '0;
					out_detail_q <= '0;
					match_q      <= '0;
					wscore_q     <= score_next;
					last_q       <= 1'b1;
				end
				default: begin
					out_type_q   <= '0;
					out_detail_q <= '0;
					match_q      <= '0;
					wscore_q     <= '0;
					last_q       <= 1'b1;
				end
			endcase
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign out_type       = out_type_q;
	assign out_detail     = out_detail_q;
	assign match_count    = match_q;
	assign weighted_score = wscore_q;
	assign last_item      = last_q;

endmodule
`default_nettype wire

// ===== sv/erl_checker.sv =====
// Port-level checks for the event ring log, bound to the top level.
// Depends on erl_pkg for command codes and widths.
`timescale 1ns / 1ps
`default_nettype none
module erl_checker (
	input wire                               clk,
	input wire                               arst_n,
	input wire                               req_valid,
	input wire                               req_stall,
	input wire [erl_pkg::CMD_W-1:0]          cmd,
	input wire                               rsp_valid,
	input wire                               rsp_stall,
	input wire [erl_pkg::TYPE_W-1:0]         out_type,
	input wire [erl_pkg::DETAIL_W-1:0]       out_detail,
	input wire [erl_pkg::MATCH_W-1:0]        match_count,
	input wire [erl_pkg::SCORE_W-1:0]        weighted_score,
	input wire                               last_item
);
	import erl_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(out_detail) && $stable(last_item))
		else $error("stalled request changed");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (cmd == CMD_COUNT || cmd == CMD_SCORE || cmd == CMD_FLUSH)
		|=> req_stall)
		else $error("query did not hold the input side");

	a_log_free: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (cmd == CMD_LOG || cmd == CMD_CLEAR) |=> !req_stall)
		else $error("log or clear held the input side");

	a_field_mix: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (out_type == '0 && out_detail == '0) ||
			(match_count == '0 && weighted_score == '0))
		else $error("flush fields mixed with query fields");

	a_partial_flush: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !last_item |-> match_count == '0 && weighted_score == '0)
		else $error("non-final request carries a query result");

endmodule

bind event_ring_log_with_weighted_score_top erl_checker u_erl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req_valid),
	.req_stall      (req_stall),
	.cmd            (cmd),
	.rsp_valid      (rsp_valid),
	.rsp_stall      (rsp_stall),
	.out_type       (out_type),
	.out_detail     (out_detail),
	.match_count    (match_count),
	.weighted_score (weighted_score),
	.last_item      (last_item)
);
`default_nettype wire
